>>> design/mstt_pkg.sv
package mstt_pkg;

    // Default geometry of the bank
    localparam int NUM_SLOTS_DEF = 16;
    localparam int TICK_BITS_DEF = 32;

    // Fixed field widths of the command and result words
    localparam int SLOT_W = 4;
    localparam int WORD_W = 32;

    // Fire events returned for one tick at most
    localparam int MAX_EVENTS = 16;
    localparam int EV_W       = $clog2(MAX_EVENTS + 1);

    // Result word kinds
    localparam logic RK_FIRE  = 1'b0;
    localparam logic RK_QUERY = 1'b1;

    typedef enum logic [2:0] {
        K_SETUP = 3'd0,
        K_START = 3'd1,
        K_STOP  = 3'd2,
        K_CLOSE = 3'd3,
        K_TICK  = 3'd4,
        K_QUERY = 3'd5
    } kind_t;

    typedef enum logic [1:0] {
        ST_CREATED = 2'd0,
        ST_STARTED = 2'd1,
        ST_STOPPED = 2'd2,
        ST_CLOSED  = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CMD,
        S_WALK
    } fsm_t;

    // Outcome of one pass of the slot update unit
    typedef struct packed {
        logic write;
        logic fire;
    } step_flags_t;

    // One result word as it leaves the bank
    typedef struct packed {
        logic              rkind;
        logic [SLOT_W-1:0] slot;
        status_t           status;
        logic [WORD_W-1:0] delay;
        logic [WORD_W-1:0] period;
        logic              cls;
        logic              last;
    } result_t;

endpackage

>>> design/mstt_ram.sv
module mstt_ram #(
    parameter int DEPTH  = 16,
    parameter int DATA_W = 8,
    parameter int ADDR_W = 4
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [DATA_W-1:0] wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> design/mstt_step.sv
module mstt_step #(
    parameter int TICK_BITS = mstt_pkg::TICK_BITS_DEF,
    parameter int ENT_W     = 3 * TICK_BITS + 3
) (
    input  mstt_pkg::kind_t       op,
    input  logic                  pass_cls,
    input  logic [TICK_BITS-1:0]  in_dly,
    input  logic [TICK_BITS-1:0]  in_per,
    input  logic                  in_cls,
    input  logic [ENT_W-1:0]      ent_in,
    output logic [ENT_W-1:0]      ent_out,
    output mstt_pkg::step_flags_t flags
);

    import mstt_pkg::*;

    typedef struct packed {
        status_t              st;
        logic                 cls;
        logic [TICK_BITS-1:0] cnt;
        logic [TICK_BITS-1:0] dly;
        logic [TICK_BITS-1:0] per;
    } entry_t;

    entry_t               ent;
    entry_t               nxt;
    logic [TICK_BITS-1:0] reload;
    logic [TICK_BITS-1:0] setup_cnt;

    assign ent       = entry_t'(ent_in);
    assign reload    = (ent.dly != '0) ? ent.dly : ent.per;
    assign setup_cnt = (in_dly != '0) ? in_dly : in_per;

    // Apply one command or one tick step to a slot entry
    always_comb
    begin
        nxt   = ent;
        flags = '0;
        unique case (op)
            K_SETUP:
            begin
                nxt.dly     = in_dly;
                nxt.per     = in_per;
                nxt.cls     = in_cls;
                nxt.cnt     = setup_cnt;
                nxt.st      = ST_CREATED;
                flags.write = 1'b1;
            end
            K_START:
            begin
                if (ent.st == ST_CREATED || ent.st == ST_STOPPED)
                begin
                    nxt.cnt     = reload;
                    nxt.st      = ST_STARTED;
                    flags.write = 1'b1;
                end
            end
            K_STOP:
            begin
                if (ent.st == ST_STARTED)
                begin
                    nxt.st      = ST_STOPPED;
                    flags.write = 1'b1;
                end
            end
            K_CLOSE:
            begin
                nxt.st      = ST_CLOSED;
                flags.write = 1'b1;
            end
            K_TICK:
            begin
                if (ent.st == ST_STARTED && ent.cls == pass_cls)
                begin
                    flags.write = 1'b1;
                    if (ent.cnt == '0)
                    begin
                        flags.fire = 1'b1;
                    end
                    else
                    begin
                        nxt.cnt    = ent.cnt - TICK_BITS'(1);
                        flags.fire = (ent.cnt == TICK_BITS'(1));
                    end
                    // Reload periodic slots, stop one-shots
                    if (flags.fire)
                    begin
                        if (ent.per != '0)
                        begin
                            nxt.cnt = ent.per;
                        end
                        else
                        begin
                            nxt.st = ST_STOPPED;
                        end
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    assign ent_out = ENT_W'(nxt);

endmodule

>>> design/multi_slot_tick_timer_bank_core.sv
// Command (setup, start, stop, close, query): busy in the S_CMD state after the accept
// edge, query answer registered there and strobed once busy drops; unused kinds and
// out-of-range non-query commands are dropped at the accept edge with no busy cycle.
// Tick: busy in S_WALK, one slot entry per cycle through the shared update unit, hard
// pass then soft pass; fire words strobed during the walk, the last one once busy drops.
// Reset: async, active low; all slots read closed with zero fields; no receiver stall.
module multi_slot_tick_timer_bank_core #(
    parameter int NUM_SLOTS = mstt_pkg::NUM_SLOTS_DEF,
    parameter int TICK_BITS = mstt_pkg::TICK_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [2:0]                    kind,
    input  logic [mstt_pkg::SLOT_W-1:0]   slot_index,
    input  logic [mstt_pkg::WORD_W-1:0]   first_delay,
    input  logic [mstt_pkg::WORD_W-1:0]   period_ticks,
    input  logic                          hard_class,
    output logic                          result_strobe,
    output logic                          result_kind,
    output logic [mstt_pkg::SLOT_W-1:0]   fired_slot,
    output logic [1:0]                    slot_status,
    output logic [mstt_pkg::WORD_W-1:0]   slot_delay,
    output logic [mstt_pkg::WORD_W-1:0]   slot_period,
    output logic                          slot_class,
    output logic                          last_of_run
);

    import mstt_pkg::*;

    localparam int IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int CNT_W = $clog2(NUM_SLOTS + 1);
    localparam int ENT_W = 3 * TICK_BITS + 3;

    typedef struct packed {
        status_t              st;
        logic                 cls;
        logic [TICK_BITS-1:0] cnt;
        logic [TICK_BITS-1:0] dly;
        logic [TICK_BITS-1:0] per;
    } entry_t;

    fsm_t                 state_reg, state_next;
    kind_t                kind_reg, kind_next;
    logic [SLOT_W-1:0]    slot_reg, slot_next;
    logic [IDX_W-1:0]     addr_reg, addr_next;
    logic                 ok_reg, ok_next;
    logic [TICK_BITS-1:0] dly_reg, dly_next;
    logic [TICK_BITS-1:0] per_reg, per_next;
    logic                 hcls_reg, hcls_next;

    logic                 pipe_vld_reg, pipe_vld_next;
    logic [IDX_W-1:0]     pipe_idx_reg, pipe_idx_next;
    logic                 pipe_cls_reg, pipe_cls_next;
    logic [CNT_W-1:0]     rd_idx_reg, rd_idx_next;
    logic [EV_W-1:0]      ev_cnt_reg, ev_cnt_next;
    logic                 pend_vld_reg, pend_vld_next;
    result_t              pend_reg, pend_next;
    logic                 out_vld_reg, out_vld_next;
    result_t              out_reg, out_next;

    logic [NUM_SLOTS-1:0] slot_vld_reg;
    logic                 rd_vld_reg;

    logic                 rd_en;
    logic [IDX_W-1:0]     rd_addr;
    logic                 wr_en;
    logic [IDX_W-1:0]     wr_addr;
    logic [ENT_W-1:0]     rd_data;
    logic [ENT_W-1:0]     step_out;
    kind_t                step_op;
    logic                 step_cls;
    step_flags_t          flags;

    entry_t               blank;
    entry_t               ent_cur;
    entry_t               ent_nx;
    result_t              ev;
    logic                 cmd_ok;
    logic [IDX_W-1:0]     cmd_addr;

    // Slot store
    mstt_ram #(
        .DEPTH  (NUM_SLOTS),
        .DATA_W (ENT_W),
        .ADDR_W (IDX_W)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (step_out),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Shared slot update unit
    mstt_step #(
        .TICK_BITS (TICK_BITS),
        .ENT_W     (ENT_W)
    ) u_step (
        .op       (step_op),
        .pass_cls (step_cls),
        .in_dly   (dly_reg),
        .in_per   (per_reg),
        .in_cls   (hcls_reg),
        .ent_in   (ENT_W'(ent_cur)),
        .ent_out  (step_out),
        .flags    (flags)
    );

    // Decode the addressed slot
    assign cmd_ok   = (32'(slot_index) < 32'(NUM_SLOTS));
    assign cmd_addr = IDX_W'(slot_index);

    // Never-written or out-of-range slots read as closed with zero fields
    always_comb
    begin
        blank    = '0;
        blank.st = ST_CLOSED;
    end

    assign ent_cur = (!rd_vld_reg || (state_reg == S_CMD && !ok_reg)) ? blank
                                                                       : entry_t'(rd_data);
    assign ent_nx  = entry_t'(step_out);

    // Fire word for the slot under update
    always_comb
    begin
        ev        = '0;
        ev.rkind  = RK_FIRE;
        ev.slot   = SLOT_W'(pipe_idx_reg);
        ev.status = ent_nx.st;
        ev.delay  = WORD_W'(ent_nx.dly);
        ev.period = WORD_W'(ent_nx.per);
        ev.cls    = ent_nx.cls;
        ev.last   = 1'b0;
    end

    // Sequencer: next state, memory access and result words
    always_comb
    begin
        state_next    = state_reg;
        kind_next     = kind_reg;
        slot_next     = slot_reg;
        addr_next     = addr_reg;
        ok_next       = ok_reg;
        dly_next      = dly_reg;
        per_next      = per_reg;
        hcls_next     = hcls_reg;
        pipe_vld_next = pipe_vld_reg;
        pipe_idx_next = pipe_idx_reg;
        pipe_cls_next = pipe_cls_reg;
        rd_idx_next   = rd_idx_reg;
        ev_cnt_next   = ev_cnt_reg;
        pend_vld_next = pend_vld_reg;
        pend_next     = pend_reg;
        out_vld_next  = 1'b0;
        out_next      = out_reg;
        rd_en         = 1'b0;
        rd_addr       = cmd_addr;
        wr_en         = 1'b0;
        wr_addr       = addr_reg;
        step_op       = K_QUERY;
        step_cls      = pipe_cls_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    kind_next = kind_t'(kind);
                    slot_next = slot_index;
                    addr_next = cmd_addr;
                    ok_next   = cmd_ok;
                    dly_next  = TICK_BITS'(first_delay);
                    per_next  = TICK_BITS'(period_ticks);
                    hcls_next = hard_class;
                    unique case (kind_t'(kind)) inside
                        K_SETUP, K_START, K_STOP, K_CLOSE:
                        begin
                            if (cmd_ok)
                            begin
                                rd_en      = 1'b1;
                                state_next = S_CMD;
                            end
                        end
                        K_QUERY:
                        begin
                            rd_en      = 1'b1;
                            state_next = S_CMD;
                        end
                        K_TICK:
                        begin
                            // Open the hard pass at slot zero
                            rd_en         = 1'b1;
                            rd_addr       = '0;
                            pipe_vld_next = 1'b1;
                            pipe_idx_next = '0;
                            pipe_cls_next = 1'b1;
                            rd_idx_next   = CNT_W'(1);
                            ev_cnt_next   = '0;
                            pend_vld_next = 1'b0;
                            state_next    = S_WALK;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_CMD:
            begin
                step_op = kind_reg;
                wr_en   = flags.write && ok_reg;
                wr_addr = addr_reg;
                if (kind_reg == K_QUERY)
                begin
                    out_vld_next    = 1'b1;
                    out_next.rkind  = RK_QUERY;
                    out_next.slot   = slot_reg;
                    out_next.status = ent_cur.st;
                    out_next.delay  = WORD_W'(ent_cur.dly);
                    out_next.period = WORD_W'(ent_cur.per);
                    out_next.cls    = ent_cur.cls;
                    out_next.last   = 1'b1;
                end
                state_next = S_IDLE;
            end
            S_WALK:
            begin
                step_op = K_TICK;
                wr_addr = pipe_idx_reg;
                if (pipe_vld_reg)
                begin
                    wr_en = flags.write;
                    // Release the held event once a later one shows up
                    if (flags.fire && ev_cnt_reg < EV_W'(MAX_EVENTS))
                    begin
                        if (pend_vld_reg)
                        begin
                            out_vld_next = 1'b1;
                            out_next     = pend_reg;
                        end
                        pend_next     = ev;
                        pend_vld_next = 1'b1;
                        ev_cnt_next   = ev_cnt_reg + EV_W'(1);
                    end
                    // Advance the walk
                    if (rd_idx_reg < CNT_W'(NUM_SLOTS))
                    begin
                        rd_en         = 1'b1;
                        rd_addr       = rd_idx_reg[IDX_W-1:0];
                        pipe_idx_next = rd_idx_reg[IDX_W-1:0];
                        rd_idx_next   = rd_idx_reg + CNT_W'(1);
                    end
                    else if (pipe_cls_reg)
                    begin
                        rd_en         = 1'b1;
                        rd_addr       = '0;
                        pipe_idx_next = '0;
                        pipe_cls_next = 1'b0;
                        rd_idx_next   = CNT_W'(1);
                    end
                    else
                    begin
                        pipe_vld_next = 1'b0;
                    end
                end
                else
                begin
                    // Flush the final event with the end mark
                    if (pend_vld_reg)
                    begin
                        out_vld_next  = 1'b1;
                        out_next      = pend_reg;
                        out_next.last = 1'b1;
                    end
                    pend_vld_next = 1'b0;
                    state_next    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pipe_vld_reg <= 1'b0;
            pend_vld_reg <= 1'b0;
            out_vld_reg  <= 1'b0;
            ev_cnt_reg   <= '0;
            slot_vld_reg <= '0;
        end
        else
        begin
            pipe_vld_reg <= pipe_vld_next;
            pend_vld_reg <= pend_vld_next;
            out_vld_reg  <= out_vld_next;
            ev_cnt_reg   <= ev_cnt_next;
            if (wr_en)
            begin
                slot_vld_reg[wr_addr] <= 1'b1;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        kind_reg     <= kind_next;
        slot_reg     <= slot_next;
        addr_reg     <= addr_next;
        ok_reg       <= ok_next;
        dly_reg      <= dly_next;
        per_reg      <= per_next;
        hcls_reg     <= hcls_next;
        pipe_idx_reg <= pipe_idx_next;
        pipe_cls_reg <= pipe_cls_next;
        rd_idx_reg   <= rd_idx_next;
        pend_reg     <= pend_next;
        out_reg      <= out_next;
        if (rd_en)
        begin
            rd_vld_reg <= slot_vld_reg[rd_addr];
        end
    end

    assign busy          = (state_reg != S_IDLE);
    assign result_strobe = out_vld_reg;
    assign result_kind   = out_reg.rkind;
    assign fired_slot    = out_reg.slot;
    assign slot_status   = out_reg.status;
    assign slot_delay    = out_reg.delay;
    assign slot_period   = out_reg.period;
    assign slot_class    = out_reg.cls;
    assign last_of_run   = out_reg.last;

    // Results only follow work in progress
    a_strobe_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        result_strobe |-> $past(busy))
        else $error("result word without preceding work");

    // A query answer always closes its run
    a_query_last: assert property (@(posedge clk) disable iff (!rst_n)
        (result_strobe && result_kind == RK_QUERY) |-> last_of_run)
        else $error("query answer without end mark");

    // Event count stays within the cap
    a_ev_cap: assert property (@(posedge clk) disable iff (!rst_n)
        ev_cnt_reg <= EV_W'(MAX_EVENTS))
        else $error("fire event count beyond cap");

    // The slot store is only written while busy
    a_wr_busy: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> busy)
        else $error("slot store written while idle");

endmodule

>>> bench/multi_slot_tick_timer_bank_core_chk.sv
module multi_slot_tick_timer_bank_core_chk #(
    parameter int NUM_SLOTS = mstt_pkg::NUM_SLOTS_DEF,
    parameter int TICK_BITS = mstt_pkg::TICK_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic                          busy,
    input  logic [2:0]                    kind,
    input  logic [mstt_pkg::SLOT_W-1:0]   slot_index,
    input  logic [mstt_pkg::WORD_W-1:0]   first_delay,
    input  logic [mstt_pkg::WORD_W-1:0]   period_ticks,
    input  logic                          hard_class,
    input  logic                          result_strobe,
    input  logic                          result_kind,
    input  logic [mstt_pkg::SLOT_W-1:0]   fired_slot,
    input  logic [1:0]                    slot_status,
    input  logic [mstt_pkg::WORD_W-1:0]   slot_delay,
    input  logic [mstt_pkg::WORD_W-1:0]   slot_period,
    input  logic                          slot_class,
    input  logic                          last_of_run,
    output int                            fail_count,
    output int                            words_pending
);

    import mstt_pkg::*;

    // Shadow copy of the slot bank
    logic [TICK_BITS-1:0] count_left  [NUM_SLOTS];
    logic [TICK_BITS-1:0] delay_held  [NUM_SLOTS];
    logic [TICK_BITS-1:0] period_held [NUM_SLOTS];
    logic                 hard_held   [NUM_SLOTS];
    status_t              state_held  [NUM_SLOTS];

    // Result words still owed by the bank, oldest first
    result_t              owed_words [$];
    int                   errors = 0;

    // Build the word that reports one slot as it stands now
    function automatic result_t slot_word(input logic rk, input int idx, input logic last);
        result_t w;
        w.rkind = rk;
        w.slot  = SLOT_W'(idx);
        if (idx < NUM_SLOTS)
        begin
            w.status = state_held[idx];
            w.delay  = WORD_W'(delay_held[idx]);
            w.period = WORD_W'(period_held[idx]);
            w.cls    = hard_held[idx];
        end
        else
        begin
            w.status = ST_CLOSED;
            w.delay  = '0;
            w.period = '0;
            w.cls    = 1'b0;
        end
        w.last = last;
        return w;
    endfunction

    function automatic string show_word(input result_t w);
        return $sformatf({"kind=%0b slot=%0d status=%0d delay=%h period=%h",
                          " class=%0b last=%0b"},
                         w.rkind, w.slot, w.status, w.delay, w.period, w.cls, w.last);
    endfunction

    function automatic void log_failure(input string msg);
        errors++;
        if (errors <= 10)
            $display("%m: mismatch: %s", msg);
    endfunction

    // Walk hard slots then soft slots, decrement, fire, reload or stop
    function automatic void tick_bank();
        result_t evs [MAX_EVENTS];
        int      n;
        logic    fire;
        logic    cls;
        n = 0;
        for (int pass = 0; pass < 2; pass++)
        begin
            cls = (pass == 0);
            for (int i = 0; i < NUM_SLOTS; i++)
            begin
                if (state_held[i] == ST_STARTED && hard_held[i] == cls)
                begin
                    if (count_left[i] == '0)
                    begin
                        fire = 1'b1;
                    end
                    else
                    begin
                        count_left[i] = count_left[i] - 1'b1;
                        fire = (count_left[i] == '0);
                    end
                    if (fire)
                    begin
                        if (period_held[i] != '0)
                            count_left[i] = period_held[i];
                        else
                            state_held[i] = ST_STOPPED;
                        if (n < MAX_EVENTS)
                        begin
                            evs[n] = slot_word(RK_FIRE, i, 1'b0);
                            n++;
                        end
                    end
                end
            end
        end
        if (n > 0)
            evs[n-1].last = 1'b1;
        for (int j = 0; j < n; j++)
            owed_words.push_back(evs[j]);
    endfunction

    // Apply one accepted command word to the shadow bank
    function automatic void apply_word();
        int   s;
        logic ok;
        s  = int'(slot_index);
        ok = (s < NUM_SLOTS);
        case (kind)
            K_SETUP:
            begin
                if (ok)
                begin
                    delay_held[s]  = TICK_BITS'(first_delay);
                    period_held[s] = TICK_BITS'(period_ticks);
                    hard_held[s]   = hard_class;
                    count_left[s]  = (delay_held[s] != '0) ? delay_held[s] : period_held[s];
                    state_held[s]  = ST_CREATED;
                end
            end
            K_START:
            begin
                if (ok && (state_held[s] == ST_CREATED || state_held[s] == ST_STOPPED))
                begin
                    count_left[s] = (delay_held[s] != '0) ? delay_held[s] : period_held[s];
                    state_held[s] = ST_STARTED;
                end
            end
            K_STOP:
            begin
                if (ok && state_held[s] == ST_STARTED)
                    state_held[s] = ST_STOPPED;
            end
            K_CLOSE:
            begin
                if (ok)
                    state_held[s] = ST_CLOSED;
            end
            K_TICK:
            begin
                tick_bank();
            end
            K_QUERY:
            begin
                owed_words.push_back(slot_word(RK_QUERY, s, 1'b1));
            end
            default:
            begin
                // drop unused kinds
            end
        endcase
    endfunction

    // Compare one strobed word against the oldest owed word
    function automatic void check_word();
        result_t got;
        result_t want;
        got.rkind  = result_kind;
        got.slot   = fired_slot;
        got.status = status_t'(slot_status);
        got.delay  = slot_delay;
        got.period = slot_period;
        got.cls    = slot_class;
        got.last   = last_of_run;
        if (owed_words.size() == 0)
        begin
            log_failure($sformatf("word with none owed: %s", show_word(got)));
        end
        else
        begin
            want = owed_words.pop_front();
            if (got.rkind !== want.rkind || got.slot !== want.slot
                    || got.status !== want.status || got.delay !== want.delay
                    || got.period !== want.period || got.cls !== want.cls
                    || got.last !== want.last)
                log_failure($sformatf("expected %s / got %s",
                                      show_word(want), show_word(got)));
        end
    endfunction

    // Check results first, then queue the words of a new command
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_SLOTS; i++)
            begin
                count_left[i]  = '0;
                delay_held[i]  = '0;
                period_held[i] = '0;
                hard_held[i]   = 1'b0;
                state_held[i]  = ST_CLOSED;
            end
            owed_words.delete();
        end
        else
        begin
            if (result_strobe)
                check_word();
            if (start && !busy)
                apply_word();
        end
        words_pending <= owed_words.size();
        fail_count    <= errors;
    end

endmodule

>>> bench/multi_slot_tick_timer_bank_core_tb.sv
module multi_slot_tick_timer_bank_core_tb;
    import mstt_pkg::*;

    localparam int NUM_SLOTS    = NUM_SLOTS_DEF;
    localparam int TICK_BITS    = TICK_BITS_DEF;
    localparam int ITEM_GOAL    = 500;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 2 * NUM_SLOTS + 8;

    // Kind codes the bank ignores
    localparam logic [2:0] K_SPARE_LO = 3'd6;
    localparam logic [2:0] K_SPARE_HI = 3'd7;

    logic              clk          = 1'b0;
    logic              rst_n        = 1'b0;
    logic              start        = 1'b0;
    logic [2:0]        kind         = K_SETUP;
    logic [SLOT_W-1:0] slot_index   = '0;
    logic [WORD_W-1:0] first_delay  = '0;
    logic [WORD_W-1:0] period_ticks = '0;
    logic              hard_class   = 1'b0;

    logic              busy;
    logic              result_strobe;
    logic              result_kind;
    logic [SLOT_W-1:0] fired_slot;
    logic [1:0]        slot_status;
    logic [WORD_W-1:0] slot_delay;
    logic [WORD_W-1:0] slot_period;
    logic              slot_class;
    logic              last_of_run;

    int fail_count;
    int words_pending;
    int cycle_count = 0;
    int items_sent  = 0;
    int idle_pct    = 0;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    multi_slot_tick_timer_bank_core #(
        .NUM_SLOTS (NUM_SLOTS),
        .TICK_BITS (TICK_BITS)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .kind          (kind),
        .slot_index    (slot_index),
        .first_delay   (first_delay),
        .period_ticks  (period_ticks),
        .hard_class    (hard_class),
        .result_strobe (result_strobe),
        .result_kind   (result_kind),
        .fired_slot    (fired_slot),
        .slot_status   (slot_status),
        .slot_delay    (slot_delay),
        .slot_period   (slot_period),
        .slot_class    (slot_class),
        .last_of_run   (last_of_run)
    );

    multi_slot_tick_timer_bank_core_chk #(
        .NUM_SLOTS (NUM_SLOTS),
        .TICK_BITS (TICK_BITS)
    ) chk (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .kind          (kind),
        .slot_index    (slot_index),
        .first_delay   (first_delay),
        .period_ticks  (period_ticks),
        .hard_class    (hard_class),
        .result_strobe (result_strobe),
        .result_kind   (result_kind),
        .fired_slot    (fired_slot),
        .slot_status   (slot_status),
        .slot_delay    (slot_delay),
        .slot_period   (slot_period),
        .slot_class    (slot_class),
        .last_of_run   (last_of_run),
        .fail_count    (fail_count),
        .words_pending (words_pending)
    );

    // Abort a hung run
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("multi_slot_tick_timer_bank_core_tb: done, errors");
            $finish;
        end
    end

    // Hold start low for random gaps, then present one word until accepted
    task automatic send_word(input logic [2:0] k, input logic [SLOT_W-1:0] s,
                             input logic [WORD_W-1:0] d, input logic [WORD_W-1:0] p,
                             input logic h);
        while ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start        <= 1'b1;
        kind         <= k;
        slot_index   <= s;
        first_delay  <= d;
        period_ticks <= p;
        hard_class   <= h;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        if (k <= K_QUERY)
            items_sent++;
    endtask

    // Non-setup command: the unused fields carry noise
    task automatic send_cmd(input logic [2:0] k, input logic [SLOT_W-1:0] s);
        send_word(k, s, $urandom, $urandom, 1'($urandom_range(1)));
    endtask

    // Mostly short counts so slots fire often, now and then a full-width one
    function automatic logic [WORD_W-1:0] short_count();
        if ($urandom_range(7) == 0)
            return $urandom;
        return $urandom_range(6);
    endfunction

    // Arm every slot to fire on the next tick
    task automatic fill_bank();
        for (int s = 0; s < 16; s++)
            send_word(K_SETUP, SLOT_W'(s), 1, $urandom_range(3), 1'($urandom_range(1)));
        for (int s = 0; s < 16; s++)
            send_cmd(K_START, SLOT_W'(s));
        send_cmd(K_TICK, '0);
    endtask

    // Mix of armed slots, ticks, queries and noise commands
    task automatic run_random(input int goal);
        int                pick;
        logic [SLOT_W-1:0] s;
        fill_bank();
        while (items_sent < goal)
        begin
            pick = $urandom_range(99);
            s    = SLOT_W'($urandom_range(15));
            if (pick < 1)
                fill_bank();
            else if (pick < 42)
            begin
                send_word(K_SETUP, s, short_count(), short_count(), 1'($urandom_range(1)));
                if ($urandom_range(3) != 0)
                    send_cmd(K_START, s);
            end
            else if (pick < 72)
                send_cmd(K_TICK, s);
            else if (pick < 83)
                send_cmd(K_QUERY, s);
            else if (pick < 90)
                send_cmd(K_STOP, s);
            else if (pick < 94)
                send_cmd(K_CLOSE, s);
            else if (pick < 98)
                send_cmd(K_START, s);
            else
                send_cmd($urandom_range(1) ? K_SPARE_HI : K_SPARE_LO, s);
        end
    endtask

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: closed slots, zero countdown, delay from period, status rules
        send_cmd(K_QUERY, SLOT_W'(0));
        send_cmd(K_START, SLOT_W'(3));
        send_cmd(K_STOP, SLOT_W'(3));
        send_cmd(K_TICK, SLOT_W'(0));
        send_word(K_SETUP, SLOT_W'(0), 0, 0, 1'b1);
        send_word(K_SETUP, SLOT_W'(15), '1, '1, 1'b0);
        send_word(K_SETUP, SLOT_W'(5), 1, 2, 1'b0);
        send_word(K_SETUP, SLOT_W'(6), 0, 1, 1'b1);
        send_cmd(K_STOP, SLOT_W'(5));
        send_cmd(K_QUERY, SLOT_W'(15));
        send_cmd(K_START, SLOT_W'(0));
        send_cmd(K_START, SLOT_W'(5));
        send_cmd(K_START, SLOT_W'(6));
        send_cmd(K_START, SLOT_W'(15));
        send_cmd(K_START, SLOT_W'(5));
        send_cmd(K_TICK, SLOT_W'(0));
        send_cmd(K_TICK, SLOT_W'(0));
        send_cmd(K_STOP, SLOT_W'(6));
        send_cmd(K_START, SLOT_W'(6));
        send_word(K_SETUP, SLOT_W'(5), 3, 0, 1'b1);
        send_cmd(K_CLOSE, SLOT_W'(15));
        send_cmd(K_QUERY, SLOT_W'(15));
        send_cmd(K_QUERY, SLOT_W'(0));
        send_cmd(K_SPARE_LO, SLOT_W'(2));
        send_cmd(K_SPARE_HI, SLOT_W'(9));
        send_cmd(K_CLOSE, SLOT_W'(0));

        // Random: sender gaps heavy, heavier, then none
        idle_pct = 34;
        run_random(items_sent + ITEM_GOAL / 3);
        idle_pct = 68;
        run_random(items_sent + ITEM_GOAL / 3);
        idle_pct = 0;
        run_random(items_sent + ITEM_GOAL / 3);

        // Drain owed words, then watch for strays
        start <= 1'b0;
        @(posedge clk);
        while (words_pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_count == 0)
            $display("multi_slot_tick_timer_bank_core_tb: done, clean");
        else
            $display("multi_slot_tick_timer_bank_core_tb: done, errors");
        $finish;
    end

endmodule

>>> filelist.f
design/mstt_pkg.sv
design/mstt_ram.sv
design/mstt_step.sv
design/multi_slot_tick_timer_bank_core.sv
bench/multi_slot_tick_timer_bank_core_chk.sv
bench/multi_slot_tick_timer_bank_core_tb.sv
